// ===== rtl/ffba_pkg.sv =====
// Shared types, codes and defaults for the first-fit block allocator.
package ffba_pkg;

   // Default geometry of the block store
   localparam int NUM_BLOCKS_DEF  = 64;
   localparam int BLOCK_UNITS_DEF = 8;

   // Fixed field widths
   localparam int TAG_W     = 8;
   localparam int SIZE_W    = 16;
   localparam int IDX_OUT_W = 6;

   // Command kinds on the request channel
   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_GET    = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_DEFRAG = 2'd3
   } kind_type;

   // Datapath phases sequenced by the controller
   typedef enum logic [2:0] {
      PH_ADD   = 3'd0,
      PH_FILL  = 3'd1,
      PH_GET   = 3'd2,
      PH_DEL   = 3'd3,
      PH_PACK  = 3'd4,
      PH_CLEAR = 3'd5,
      PH_LIST  = 3'd6
   } phase_type;

   // Controller to datapath
   typedef struct packed {
      logic      accept;
      logic      start;
      phase_type phase;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic done;
      logic hit;
      logic freed;
   } status_type;

endpackage

// ===== rtl/ffba_ctrl.sv =====
// Command sequencer: walks each command through its datapath phases.
module ffba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_kind,
   input  ffba_pkg::status_type   status,
   output ffba_pkg::cmd_type      cmd
);
   import ffba_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ADD   = 8'b0000_0010,
      ST_FILL  = 8'b0000_0100,
      ST_GET   = 8'b0000_1000,
      ST_DEL   = 8'b0001_0000,
      ST_PACK  = 8'b0010_0000,
      ST_CLEAR = 8'b0100_0000,
      ST_LIST  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      start_ff, start_in;
   kind_type  kind;
   phase_type phase;
   logic      accept;

   assign kind       = kind_type'(req_kind);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      start_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               start_in = 1'b1;
               unique case (kind)
                  KIND_ADD:    state_in = ST_ADD;
                  KIND_GET:    state_in = ST_GET;
                  KIND_DELETE: state_in = ST_DEL;
                  KIND_DEFRAG: state_in = ST_PACK;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            if (status.done) begin
               if (status.hit) begin
                  state_in = ST_FILL;
                  start_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DEL: begin
            if (status.done) begin
               if (status.freed) begin
                  state_in = ST_LIST;
                  start_in = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PACK: begin
            if (status.done) begin
               state_in = ST_CLEAR;
               start_in = 1'b1;
            end
         end
         ST_CLEAR: begin
            if (status.done) begin
               state_in = ST_LIST;
               start_in = 1'b1;
            end
         end
         ST_FILL, ST_GET, ST_LIST: begin
            if (status.done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Phase per state
   always_comb begin
      unique case (state_ff)
         ST_ADD:   phase = PH_ADD;
         ST_FILL:  phase = PH_FILL;
         ST_GET:   phase = PH_GET;
         ST_DEL:   phase = PH_DEL;
         ST_PACK:  phase = PH_PACK;
         ST_CLEAR: phase = PH_CLEAR;
         ST_LIST:  phase = PH_LIST;
         default:  phase = PH_ADD;
      endcase
   end

   assign cmd.accept = accept;
   assign cmd.start  = start_ff;
   assign cmd.phase  = phase;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

endmodule

// ===== rtl/ffba_datapath.sv =====
// Block store, scan counters, run tracking and the result word register.
module ffba_datapath #(
   parameter int NUM_BLOCKS  = ffba_pkg::NUM_BLOCKS_DEF,
   parameter int BLOCK_UNITS = ffba_pkg::BLOCK_UNITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ffba_pkg::cmd_type               cmd,
   output ffba_pkg::status_type            status,
   input  logic [ffba_pkg::TAG_W-1:0]      req_descriptor,
   input  logic [ffba_pkg::SIZE_W-1:0]     req_size,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [ffba_pkg::TAG_W-1:0]      rsp_owner,
   output logic [ffba_pkg::IDX_OUT_W-1:0]  rsp_first,
   output logic [ffba_pkg::IDX_OUT_W-1:0]  rsp_last_block,
   output logic                            rsp_found,
   output logic                            rsp_last
);
   import ffba_pkg::*;

   localparam int IW = $clog2(NUM_BLOCKS);
   localparam int CW = $clog2(NUM_BLOCKS + 1);
   localparam int UW = $clog2(NUM_BLOCKS * BLOCK_UNITS + 1);
   localparam int SW = ((UW > SIZE_W) ? UW : SIZE_W) + 1;
   localparam int XW = IW + IDX_OUT_W;
   localparam logic [CW-1:0] N_C      = CW'(NUM_BLOCKS);
   localparam logic [CW-1:0] LAST_C   = CW'(NUM_BLOCKS - 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BLOCKS - 1);

   // Block store: owner tag per block, valid bits make unwritten blocks free
   logic [TAG_W-1:0]      owner_mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] vld_ff;
   logic [TAG_W-1:0]      mem_q_ff;
   logic                  vld_q_ff;
   logic                  we, re;
   logic [IW-1:0]         waddr, raddr;
   logic [TAG_W-1:0]      wdata;

   // Control registers
   phase_type     phase_ff, phase_in;
   logic          run_ff, run_in;
   logic          fin_ff, fin_in;
   logic          wact_ff, wact_in;
   logic          dv_ff, dv_in;
   logic          sent_ff, sent_in;
   logic          pend_v_ff, pend_v_in;
   logic          out_v_ff, out_v_in;

   // Payload registers
   logic [CW-1:0]     rd_cnt_ff, rd_cnt_in;
   logic              dend_ff, dend_in;
   logic [IW-1:0]     didx_ff, didx_in;
   logic [TAG_W-1:0]  desc_ff, desc_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [CW-1:0]     w_cnt_ff, w_cnt_in;
   logic [UW-1:0]     runu_ff, runu_in;
   logic [IW-1:0]     rstart_ff, rstart_in;
   logic              hit_ff, hit_in;
   logic              freed_ff, freed_in;
   logic [IW-1:0]     first_ff, first_in;
   logic [IW-1:0]     last_ff, last_in;
   logic [TAG_W-1:0]  cur_tag_ff, cur_tag_in;
   logic [IW-1:0]     cur_start_ff, cur_start_in;
   logic [TAG_W-1:0]  pend_tag_ff, pend_tag_in;
   logic [IW-1:0]     pend_first_ff, pend_first_in;
   logic [IW-1:0]     pend_last_ff, pend_last_in;
   logic [TAG_W-1:0]  out_owner_ff, out_owner_in;
   logic [IDX_OUT_W-1:0] out_first_ff, out_first_in;
   logic [IDX_OUT_W-1:0] out_lastb_ff, out_lastb_in;
   logic              out_found_ff, out_found_in;
   logic              out_tlast_ff, out_tlast_in;

   // Working signals
   logic [TAG_W-1:0] tag, t_eff;
   logic             load_ok, stall, list_close, done;
   logic [IW-1:0]    run_last, start_k;
   logic [SW-1:0]    sum;
   logic             emit, e_found, e_tlast;
   logic [TAG_W-1:0] e_owner;
   logic [IW-1:0]    e_first, e_last;
   logic [XW-1:0]    first_x, last_x;

   assign tag     = vld_q_ff ? mem_q_ff : '0;
   assign t_eff   = dend_ff ? '0 : tag;
   assign load_ok = !out_v_ff || rsp_tready;
   assign raddr   = rd_cnt_ff[IW-1:0];
   assign first_x = XW'(e_first);
   assign last_x  = XW'(e_last);

   always_comb begin
      phase_in      = phase_ff;
      run_in        = run_ff;
      fin_in        = fin_ff;
      wact_in       = wact_ff;
      dv_in         = dv_ff;
      sent_in       = sent_ff;
      pend_v_in     = pend_v_ff;
      rd_cnt_in     = rd_cnt_ff;
      dend_in       = dend_ff;
      didx_in       = didx_ff;
      desc_in       = desc_ff;
      size_in       = size_ff;
      w_cnt_in      = w_cnt_ff;
      runu_in       = runu_ff;
      rstart_in     = rstart_ff;
      hit_in        = hit_ff;
      freed_in      = freed_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      cur_tag_in    = cur_tag_ff;
      cur_start_in  = cur_start_ff;
      pend_tag_in   = pend_tag_ff;
      pend_first_in = pend_first_ff;
      pend_last_in  = pend_last_ff;
      we      = 1'b0;
      re      = 1'b0;
      waddr   = didx_ff;
      wdata   = '0;
      done    = 1'b0;
      emit    = 1'b0;
      e_owner = pend_tag_ff;
      e_first = pend_first_ff;
      e_last  = pend_last_ff;
      e_found = 1'b1;
      e_tlast = 1'b0;
      start_k = (runu_ff == '0) ? didx_ff : rstart_ff;
      sum     = SW'(runu_ff) + SW'(BLOCK_UNITS);

      // Run closing during a listing pass; flush the held run first
      run_last   = dend_ff ? LAST_IDX : didx_ff - IW'(1);
      list_close = run_ff && dv_ff && (phase_ff == PH_LIST) &&
                   (t_eff != cur_tag_ff) && (cur_tag_ff != '0);
      stall      = 1'b0;
      if (list_close && pend_v_ff) begin
         emit  = 1'b1;
         stall = !load_ok;
      end

      // Latch the command fields
      if (cmd.accept) begin
         desc_in = req_descriptor;
         size_in = req_size;
      end

      priority if (cmd.start) begin
         phase_in  = cmd.phase;
         rd_cnt_in = '0;
         dv_in     = 1'b0;
         sent_in   = 1'b0;
         fin_in    = 1'b0;
         unique case (cmd.phase)
            PH_ADD: begin
               run_in  = 1'b1;
               runu_in = '0;
               hit_in  = 1'b0;
            end
            PH_GET: begin
               run_in = 1'b1;
               hit_in = 1'b0;
            end
            PH_DEL: begin
               run_in   = 1'b1;
               freed_in = 1'b0;
            end
            PH_PACK: begin
               run_in   = 1'b1;
               w_cnt_in = '0;
            end
            PH_LIST: begin
               run_in     = 1'b1;
               cur_tag_in = '0;
               pend_v_in  = 1'b0;
            end
            PH_FILL: begin
               wact_in  = 1'b1;
               w_cnt_in = CW'(first_ff);
            end
            PH_CLEAR: begin
               wact_in = 1'b1;
            end
            default: ;
         endcase
      end else if (run_ff) begin
         if (!stall) begin
            // Issue the next read, then one end-of-store marker
            if (rd_cnt_ff != N_C) begin
               re        = 1'b1;
               rd_cnt_in = rd_cnt_ff + CW'(1);
               dv_in     = 1'b1;
               dend_in   = 1'b0;
               didx_in   = rd_cnt_ff[IW-1:0];
            end else if (!sent_ff) begin
               dv_in   = 1'b1;
               dend_in = 1'b1;
               sent_in = 1'b1;
            end else begin
               dv_in = 1'b0;
            end

            // Look at the block returned by the previous read
            if (dv_ff) begin
               unique case (phase_ff)
                  PH_ADD: begin
                     if (!dend_ff) begin
                        if (tag == '0) begin
                           rstart_in = start_k;
                           runu_in   = sum[UW-1:0];
                           if ((desc_ff != '0) && (size_ff != '0) &&
                               (sum >= SW'(size_ff))) begin
                              hit_in   = 1'b1;
                              first_in = start_k;
                              last_in  = didx_ff;
                              run_in   = 1'b0;
                              fin_in   = 1'b1;
                           end
                        end else begin
                           runu_in = '0;
                        end
                     end
                  end
                  PH_GET: begin
                     if (!dend_ff && (desc_ff != '0) && (tag == desc_ff)) begin
                        if (!hit_ff) begin
                           first_in = didx_ff;
                        end
                        hit_in  = 1'b1;
                        last_in = didx_ff;
                     end
                  end
                  PH_DEL: begin
                     if (!dend_ff && (desc_ff != '0) && (tag == desc_ff)) begin
                        we       = 1'b1;
                        waddr    = didx_ff;
                        wdata    = '0;
                        freed_in = 1'b1;
                     end
                  end
                  PH_PACK: begin
                     if (!dend_ff && (tag != '0)) begin
                        we       = 1'b1;
                        waddr    = w_cnt_ff[IW-1:0];
                        wdata    = tag;
                        w_cnt_in = w_cnt_ff + CW'(1);
                     end
                  end
                  PH_LIST: begin
                     if (t_eff != cur_tag_ff) begin
                        if (list_close) begin
                           pend_v_in     = 1'b1;
                           pend_tag_in   = cur_tag_ff;
                           pend_first_in = cur_start_ff;
                           pend_last_in  = run_last;
                        end
                        cur_tag_in   = t_eff;
                        cur_start_in = didx_ff;
                     end
                  end
                  default: ;
               endcase
               if (dend_ff) begin
                  run_in = 1'b0;
                  fin_in = 1'b1;
               end
            end
         end
      end else if (fin_ff) begin
         // Closing step of a scan
         unique case (phase_ff)
            PH_ADD, PH_GET: begin
               emit    = 1'b1;
               e_owner = desc_ff;
               e_first = hit_ff ? first_ff : '0;
               e_last  = hit_ff ? last_ff : '0;
               e_found = hit_ff;
               e_tlast = 1'b1;
               if (load_ok) begin
                  fin_in = 1'b0;
                  done   = 1'b1;
               end
            end
            PH_LIST: begin
               if (pend_v_ff) begin
                  emit    = 1'b1;
                  e_tlast = 1'b1;
                  if (load_ok) begin
                     pend_v_in = 1'b0;
                     fin_in    = 1'b0;
                     done      = 1'b1;
                  end
               end else begin
                  fin_in = 1'b0;
                  done   = 1'b1;
               end
            end
            default: begin
               fin_in = 1'b0;
               done   = 1'b1;
            end
         endcase
      end else if (wact_ff) begin
         // Write-only sweeps
         if (phase_ff == PH_FILL) begin
            we       = 1'b1;
            waddr    = w_cnt_ff[IW-1:0];
            wdata    = desc_ff;
            w_cnt_in = w_cnt_ff + CW'(1);
            if (w_cnt_ff[IW-1:0] == last_ff) begin
               wact_in = 1'b0;
               done    = 1'b1;
            end
         end else begin
            if (w_cnt_ff != N_C) begin
               we       = 1'b1;
               waddr    = w_cnt_ff[IW-1:0];
               wdata    = '0;
               w_cnt_in = w_cnt_ff + CW'(1);
               if (w_cnt_ff == LAST_C) begin
                  wact_in = 1'b0;
                  done    = 1'b1;
               end
            end else begin
               wact_in = 1'b0;
               done    = 1'b1;
            end
         end
      end else begin
         // Idle: everything holds
      end
   end

   // Result word register
   always_comb begin
      out_v_in     = out_v_ff;
      out_owner_in = out_owner_ff;
      out_first_in = out_first_ff;
      out_lastb_in = out_lastb_ff;
      out_found_in = out_found_ff;
      out_tlast_in = out_tlast_ff;
      if (emit && load_ok) begin
         out_v_in     = 1'b1;
         out_owner_in = e_owner;
         out_first_in = first_x[IDX_OUT_W-1:0];
         out_lastb_in = last_x[IDX_OUT_W-1:0];
         out_found_in = e_found;
         out_tlast_in = e_tlast;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   assign status.done  = done;
   assign status.hit   = hit_ff;
   assign status.freed = freed_ff;

   assign rsp_tvalid     = out_v_ff;
   assign rsp_owner      = out_owner_ff;
   assign rsp_first      = out_first_ff;
   assign rsp_last_block = out_lastb_ff;
   assign rsp_found      = out_found_ff;
   assign rsp_last       = out_tlast_ff;

   // Store array and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         owner_mem[waddr] <= wdata;
      end
      if (re) begin
         mem_q_ff <= owner_mem[raddr];
         vld_q_ff <= vld_ff[raddr];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (we) begin
         vld_ff[waddr] <= 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_ADD;
         run_ff    <= 1'b0;
         fin_ff    <= 1'b0;
         wact_ff   <= 1'b0;
         dv_ff     <= 1'b0;
         sent_ff   <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         run_ff    <= run_in;
         fin_ff    <= fin_in;
         wact_ff   <= wact_in;
         dv_ff     <= dv_in;
         sent_ff   <= sent_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      rd_cnt_ff     <= rd_cnt_in;
      dend_ff       <= dend_in;
      didx_ff       <= didx_in;
      desc_ff       <= desc_in;
      size_ff       <= size_in;
      w_cnt_ff      <= w_cnt_in;
      runu_ff       <= runu_in;
      rstart_ff     <= rstart_in;
      hit_ff        <= hit_in;
      freed_ff      <= freed_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      cur_tag_ff    <= cur_tag_in;
      cur_start_ff  <= cur_start_in;
      pend_tag_ff   <= pend_tag_in;
      pend_first_ff <= pend_first_in;
      pend_last_ff  <= pend_last_in;
      out_owner_ff  <= out_owner_in;
      out_first_ff  <= out_first_in;
      out_lastb_ff  <= out_lastb_in;
      out_found_ff  <= out_found_in;
      out_tlast_ff  <= out_tlast_in;
   end

endmodule

// ===== rtl/first_fit_block_allocator_core.sv =====
// A store scan reads one block a cycle, but a stalled result word holds a listing scan.
// Add: scan up to the first fitting free run, send the result word, then fill the run on a hit.
// Get: a full store scan, then one result word with the first and last owned block.
// Delete: a scan that frees the owned blocks, plus a listing pass if blocks were freed.
// Defragment: pack scan, clear sweep of the blocks above the packed ones, then a listing pass.
// One command at a time; a stalled result word holds the listing scan. Reset (synchronous,
// active high) clears the per-block valid bits: all blocks free at once.
module first_fit_block_allocator_core #(
   parameter int NUM_BLOCKS  = ffba_pkg::NUM_BLOCKS_DEF,
   parameter int BLOCK_UNITS = ffba_pkg::BLOCK_UNITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] descriptor, [23:8] size_units
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] owner, [13:8] first_block, [19:14] last_block, pad
   output logic [0:0]  rsp_tuser,   // [0] found
   output logic        rsp_tlast
);
   import ffba_pkg::*;

   cmd_type             cmd;
   status_type          status;
   logic [TAG_W-1:0]     rsp_owner;
   logic [IDX_OUT_W-1:0] rsp_first;
   logic [IDX_OUT_W-1:0] rsp_last_block;
   logic                 rsp_found;

   ffba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   ffba_datapath #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_UNITS (BLOCK_UNITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_descriptor (req_tdata[7:0]),
      .req_size       (req_tdata[23:8]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_owner      (rsp_owner),
      .rsp_first      (rsp_first),
      .rsp_last_block (rsp_last_block),
      .rsp_found      (rsp_found),
      .rsp_last       (rsp_tlast)
   );

   // Pack the result word
   assign rsp_tdata = {4'b0000, rsp_last_block, rsp_first, rsp_owner};
   assign rsp_tuser = rsp_found;

endmodule
